// File: hw/rtl/dpb_pkg.sv
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    localparam int CFG_W      = 16;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 4;
    localparam int REG_IDX_W  = 2;
    localparam int COLOR_W    = 8;
    localparam int POS_W      = 32;
    localparam int Z_W        = 16;
    localparam int FRAC_SHIFT = 4;
    localparam int OUT_TDATA_W = 2 * POS_W + Z_W + 3 * COLOR_W;

    localparam logic [REG_IDX_W-1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_X = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y = 2'd3;

    localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd8000;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd8000;
    localparam logic [CFG_W-1:0] CENTRE_X_RST = 16'd5120;
    localparam logic [CFG_W-1:0] CENTRE_Y_RST = 16'd3840;

    localparam logic [POS_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] focal_x;
        logic [CFG_W-1:0] focal_y;
        logic [CFG_W-1:0] centre_x;
        logic [CFG_W-1:0] centre_y;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic [Z_W-1:0] z;
        color_t         color;
    } side_t;

    // sign and zero flag of one axis, carried beside the quotient
    typedef struct packed {
        logic neg;
        logic zero;
    } axis_tag_t;

    function automatic int mag_bits(int cw);
        return (cw + FRAC_SHIFT > CFG_W) ? cw + FRAC_SHIFT : CFG_W;
    endfunction

endpackage

// File: hw/rtl/dpb_apb.sv
module dpb_apb (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpb_pkg::APB_AW-1:0]  paddr,
    input  logic [dpb_pkg::APB_DW-1:0]  pwdata,
    output logic [dpb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output dpb_pkg::cfg_t               cfg
);
    import dpb_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[APB_AW-1:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                REG_FOCAL_X:  cfg_next.focal_x  = pwdata[CFG_W-1:0];
                REG_FOCAL_Y:  cfg_next.focal_y  = pwdata[CFG_W-1:0];
                REG_CENTRE_X: cfg_next.centre_x = pwdata[CFG_W-1:0];
                REG_CENTRE_Y: cfg_next.centre_y = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x  <= FOCAL_X_RST;
            cfg_reg.focal_y  <= FOCAL_Y_RST;
            cfg_reg.centre_x <= CENTRE_X_RST;
            cfg_reg.centre_y <= CENTRE_Y_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_FOCAL_X:  prdata = APB_DW'(cfg_reg.focal_x);
            REG_FOCAL_Y:  prdata = APB_DW'(cfg_reg.focal_y);
            REG_CENTRE_X: prdata = APB_DW'(cfg_reg.centre_x);
            REG_CENTRE_Y: prdata = APB_DW'(cfg_reg.centre_y);
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/dpb_front.sv
module dpb_front #(
    parameter int CW = dpb_pkg::COORD_BITS_DEF,
    parameter int DW = dpb_pkg::DEPTH_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic [1:0]                                     en,
    input  logic [CW-1:0]                                  pix,
    input  logic [dpb_pkg::CFG_W-1:0]                      centre,
    input  logic [DW-1:0]                                  depth,
    output logic [dpb_pkg::mag_bits(CW)+DW-1:0]            prod,
    output dpb_pkg::axis_tag_t                             tag
);
    import dpb_pkg::*;

    localparam int MW = mag_bits(CW);
    localparam int PW = MW + DW;

    logic [MW:0]   p16;
    logic [MW:0]   cen;
    logic          neg;
    logic [MW:0]   diff;

    logic [MW-1:0] mag_reg;
    logic [DW-1:0] depth_reg;
    logic          neg_reg;
    logic [PW-1:0] prod_reg;
    axis_tag_t     tag_reg;

    assign p16  = (MW + 1)'({pix, {FRAC_SHIFT{1'b0}}});
    assign cen  = (MW + 1)'(centre);
    assign neg  = p16 < cen;
    assign diff = neg ? (cen - p16) : (p16 - cen);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mag_reg   <= diff[MW-1:0];
            neg_reg   <= neg;
            depth_reg <= depth;
        end
        if (en[1]) begin
            prod_reg     <= PW'(mag_reg) * PW'(depth_reg);
            tag_reg.neg  <= neg_reg;
            tag_reg.zero <= (mag_reg == '0);
        end
    end

    assign prod = prod_reg;
    assign tag  = tag_reg;

endmodule

// File: hw/rtl/dpb_div.sv
module dpb_div #(
    parameter int PW = 32,
    parameter int FW = dpb_pkg::CFG_W
) (
    input  logic                aclk,
    input  logic [PW-1:0]       en,
    input  logic [PW-1:0]       num,
    input  logic [FW-1:0]       den,
    input  dpb_pkg::axis_tag_t  tag_in,
    output logic [PW-1:0]       quo,
    output dpb_pkg::axis_tag_t  tag_out
);
    import dpb_pkg::*;

    logic [FW-1:0] rem_reg [PW];
    logic [PW-1:0] w_reg   [PW];
    axis_tag_t     tag_reg [PW];

    for (genvar k = 0; k < PW; k++) begin : g_stage
        logic [FW-1:0] rem_in;
        logic [PW-1:0] w_in;
        axis_tag_t     t_in;
        logic [FW:0]   t;
        logic [FW:0]   d;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign w_in   = num;
            assign t_in   = tag_in;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign w_in   = w_reg[k-1];
            assign t_in   = tag_reg[k-1];
        end

        assign t  = {rem_in, w_in[PW-1]};
        assign ge = t >= {1'b0, den};
        assign d  = t - {1'b0, den};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= ge ? d[FW-1:0] : t[FW-1:0];
                w_reg[k]   <= {w_in[PW-2:0], ge};
                tag_reg[k] <= t_in;
            end
        end
    end

    assign quo     = w_reg[PW-1];
    assign tag_out = tag_reg[PW-1];

endmodule

// File: hw/rtl/depth_pixel_backprojection.sv
// Back-projects one depth pixel per clock, unless the output stalls, into a point (x, y,
// z, RGB) through a pinhole model set by four APB registers. Registers hold |u*16 - c|,
// then its product with depth, then each quotient bit of the pipelined restoring divider
// per axis, then the result saturated into the output register. Throughput is one item
// per cycle while the output is not stalled. Pixels with zero depth or the invalid flag
// are accepted and yield no item; empty stages close up under a stall, so s_tready stays
// high until every stage holds an item.
// Write the registers only while no item is in flight.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // col, row, depth, blue_in, green_in, red_in; zero padded to bytes
    input  logic [((2 * COORD_BITS + DEPTH_BITS + 3 * dpb_pkg::COLOR_W + 7) / 8) * 8 - 1:0]
                                       s_tdata,
    // depth_invalid
    input  logic                       s_tuser,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // x_pos, y_pos, z_pos, red_out, green_out, blue_out
    output logic [dpb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dpb_pkg::APB_AW-1:0] paddr,
    input  logic [dpb_pkg::APB_DW-1:0] pwdata,
    output logic [dpb_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import dpb_pkg::*;

    localparam int MW     = mag_bits(COORD_BITS);
    localparam int PW     = MW + DEPTH_BITS;
    localparam int NS     = PW + 3;
    localparam int QX     = (PW > POS_W + 1) ? PW : POS_W + 1;
    localparam int COL_LO = 0;
    localparam int ROW_LO = COORD_BITS;
    localparam int DEP_LO = 2 * COORD_BITS;
    localparam int BLU_LO = DEP_LO + DEPTH_BITS;
    localparam int GRN_LO = BLU_LO + COLOR_W;
    localparam int RED_LO = GRN_LO + COLOR_W;

    cfg_t                  cfg;
    logic [COORD_BITS-1:0] in_col;
    logic [COORD_BITS-1:0] in_row;
    logic [DEPTH_BITS-1:0] in_depth;
    side_t                 in_side;
    logic                  in_keep;

    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         valid_next;
    logic [NS-1:0]         en;

    logic [PW-1:0]         prod_ax [2];
    axis_tag_t             ftag_ax [2];
    logic [PW-1:0]         q_ax    [2];
    axis_tag_t             dtag_ax [2];
    logic [POS_W-1:0]      sat_ax  [2];

    side_t                 side_reg [NS-1];
    side_t                 out_side_reg;
    logic [POS_W-1:0]      x_reg;
    logic [POS_W-1:0]      y_reg;

    dpb_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_col            = s_tdata[COL_LO +: COORD_BITS];
    assign in_row            = s_tdata[ROW_LO +: COORD_BITS];
    assign in_depth          = s_tdata[DEP_LO +: DEPTH_BITS];
    assign in_side.z         = Z_W'(in_depth);
    assign in_side.color.red   = s_tdata[RED_LO +: COLOR_W];
    assign in_side.color.green = s_tdata[GRN_LO +: COLOR_W];
    assign in_side.color.blue  = s_tdata[BLU_LO +: COLOR_W];
    assign in_keep           = s_tvalid && !s_tuser && (in_depth != '0);

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_comb begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = in_keep;
        end
        for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    dpb_front #(.CW(COORD_BITS), .DW(DEPTH_BITS)) u_front_x (
        .aclk   (aclk),
        .en     (en[1:0]),
        .pix    (in_col),
        .centre (cfg.centre_x),
        .depth  (in_depth),
        .prod   (prod_ax[0]),
        .tag    (ftag_ax[0])
    );

    dpb_front #(.CW(COORD_BITS), .DW(DEPTH_BITS)) u_front_y (
        .aclk   (aclk),
        .en     (en[1:0]),
        .pix    (in_row),
        .centre (cfg.centre_y),
        .depth  (in_depth),
        .prod   (prod_ax[1]),
        .tag    (ftag_ax[1])
    );

    dpb_div #(.PW(PW), .FW(CFG_W)) u_div_x (
        .aclk    (aclk),
        .en      (en[PW+1:2]),
        .num     (prod_ax[0]),
        .den     (cfg.focal_x),
        .tag_in  (ftag_ax[0]),
        .quo     (q_ax[0]),
        .tag_out (dtag_ax[0])
    );

    dpb_div #(.PW(PW), .FW(CFG_W)) u_div_y (
        .aclk    (aclk),
        .en      (en[PW+1:2]),
        .num     (prod_ax[1]),
        .den     (cfg.focal_y),
        .tag_in  (ftag_ax[1]),
        .quo     (q_ax[1]),
        .tag_out (dtag_ax[1])
    );

    // clamp to signed 32 bits; a zero numerator gives zero even with a zero focal length
    always_comb begin
        logic [QX-1:0] qe;
        logic          big;
        for (int a = 0; a < 2; a++) begin
            qe  = QX'(q_ax[a]);
            big = |qe[QX-1:POS_W-1];
            if (dtag_ax[a].zero) begin
                sat_ax[a] = '0;
            end else if (!dtag_ax[a].neg) begin
                sat_ax[a] = big ? SAT_POS : qe[POS_W-1:0];
            end else begin
                sat_ax[a] = big ? SAT_NEG : (POS_W'(0) - qe[POS_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= in_side;
        end
        for (int i = 1; i < NS - 1; i++) begin
            if (en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (en[NS-1]) begin
            out_side_reg <= side_reg[NS-2];
            x_reg        <= sat_ax[0];
            y_reg        <= sat_ax[1];
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {out_side_reg.color.blue, out_side_reg.color.green,
                       out_side_reg.color.red, out_side_reg.z, y_reg, x_reg};

`ifndef ASSERT_OFF
    a_drop_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !valid_reg[0])
        else $error("flagged pixel entered the pipeline");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(s_tready && in_keep)) - int'($past(m_tvalid && m_tready))))
        else $error("item lost or duplicated in pipeline");

    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg != '1) |-> s_tready)
        else $error("input stalled while a stage is empty");

    a_sign_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NS-2] && !dtag_ax[0].neg) |-> !sat_ax[0][POS_W-1])
        else $error("non-negative x offset gave negative x");
`endif

endmodule

// File: verif/point_checker.sv
module point_checker #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF,
    parameter int S_TDATA_W  = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // col, row, depth, blue_in, green_in, red_in
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // depth_invalid
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // x_pos, y_pos, z_pos, red_out, green_out, blue_out
    input  logic [dpb_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpb_pkg::APB_AW-1:0]      paddr,
    input  logic [dpb_pkg::APB_DW-1:0]      pwdata,
    input  logic [dpb_pkg::APB_DW-1:0]      prdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending,
    output int                              points_checked
);
    import dpb_pkg::*;

    localparam int ROW_LSB = COORD_BITS;
    localparam int DEP_LSB = 2 * COORD_BITS;
    localparam int BLU_LSB = DEP_LSB + DEPTH_BITS;
    localparam int GRN_LSB = BLU_LSB + COLOR_W;
    localparam int RED_LSB = GRN_LSB + COLOR_W;
    localparam int Z_LSB   = 2 * POS_W;
    localparam int OR_LSB  = Z_LSB + Z_W;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [Z_W-1:0]   z;
        color_t           color;
    } point_t;

    cfg_t   camera;
    point_t expected_points[$];

    // (pix*16 - centre) * depth / focal, truncated toward zero, saturated
    function automatic logic [POS_W-1:0] backproject_axis(
        input logic [63:0] pix,
        input logic [63:0] centre,
        input logic [63:0] depth,
        input logic [63:0] focal
    );
        logic [63:0] pix_q4;
        logic        neg;
        logic [63:0] pix_off;
        logic [63:0] prod;
        logic [63:0] quo;
        pix_q4  = pix << FRAC_SHIFT;
        neg     = pix_q4 < centre;
        pix_off = neg ? centre - pix_q4 : pix_q4 - centre;
        prod    = pix_off * depth;
        if (prod == 0)
            return '0;
        if (focal == 0)
            return neg ? SAT_NEG : SAT_POS;
        quo = prod / focal;
        if (!neg)
            return (quo > 64'(SAT_POS)) ? SAT_POS : quo[POS_W-1:0];
        if (quo >= 64'(SAT_NEG))
            return SAT_NEG;
        return -quo[POS_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %0h, expected %0h (point %0d)",
                 $time, what, got, want, points_checked);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        point_t           want;
        logic [63:0]      dep;
        logic [CFG_W-1:0] reg_now;
        if (!aresetn) begin
            camera = '{FOCAL_X_RST, FOCAL_Y_RST, CENTRE_X_RST, CENTRE_Y_RST};
            expected_points.delete();
            fail_count     = 0;
            pending        = 0;
            points_checked = 0;
        end else begin
            if (psel && penable && pready) begin
                case (paddr[REG_IDX_W+1:2])
                    REG_FOCAL_X:  reg_now = camera.focal_x;
                    REG_FOCAL_Y:  reg_now = camera.focal_y;
                    REG_CENTRE_X: reg_now = camera.centre_x;
                    default:      reg_now = camera.centre_y;
                endcase
                if (pwrite) begin
                    case (paddr[REG_IDX_W+1:2])
                        REG_FOCAL_X:  camera.focal_x  = pwdata[CFG_W-1:0];
                        REG_FOCAL_Y:  camera.focal_y  = pwdata[CFG_W-1:0];
                        REG_CENTRE_X: camera.centre_x = pwdata[CFG_W-1:0];
                        default:      camera.centre_y = pwdata[CFG_W-1:0];
                    endcase
                end else if (prdata !== APB_DW'(reg_now)) begin
                    report_mismatch("register read", 64'(prdata), 64'(reg_now));
                end
            end

            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("point with none pending", 64'(m_tdata[POS_W-1:0]), '0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_tdata[0 +: POS_W] !== want.x)
                        report_mismatch("x_pos", 64'(m_tdata[0 +: POS_W]), 64'(want.x));
                    if (m_tdata[POS_W +: POS_W] !== want.y)
                        report_mismatch("y_pos", 64'(m_tdata[POS_W +: POS_W]), 64'(want.y));
                    if (m_tdata[Z_LSB +: Z_W] !== want.z)
                        report_mismatch("z_pos", 64'(m_tdata[Z_LSB +: Z_W]), 64'(want.z));
                    if (m_tdata[OR_LSB +: COLOR_W] !== want.color.red)
                        report_mismatch("red_out", 64'(m_tdata[OR_LSB +: COLOR_W]),
                                        64'(want.color.red));
                    if (m_tdata[OR_LSB + COLOR_W +: COLOR_W] !== want.color.green)
                        report_mismatch("green_out",
                                        64'(m_tdata[OR_LSB + COLOR_W +: COLOR_W]),
                                        64'(want.color.green));
                    if (m_tdata[OR_LSB + 2 * COLOR_W +: COLOR_W] !== want.color.blue)
                        report_mismatch("blue_out",
                                        64'(m_tdata[OR_LSB + 2 * COLOR_W +: COLOR_W]),
                                        64'(want.color.blue));
                    points_checked++;
                end
            end

            if (s_tvalid && s_tready) begin
                dep = 64'(s_tdata[DEP_LSB +: DEPTH_BITS]);
                if (dep != 0 && !s_tuser) begin
                    want.x = backproject_axis(64'(s_tdata[0 +: COORD_BITS]),
                                              64'(camera.centre_x), dep, 64'(camera.focal_x));
                    want.y = backproject_axis(64'(s_tdata[ROW_LSB +: COORD_BITS]),
                                              64'(camera.centre_y), dep, 64'(camera.focal_y));
                    want.z           = dep[Z_W-1:0];
                    want.color.red   = s_tdata[RED_LSB +: COLOR_W];
                    want.color.green = s_tdata[GRN_LSB +: COLOR_W];
                    want.color.blue  = s_tdata[BLU_LSB +: COLOR_W];
                    expected_points.insert(expected_points.size(), want);
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

// File: verif/tb.sv
module tb;
    import dpb_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int DEPTH_BITS  = DEPTH_BITS_DEF;
    localparam int S_TDATA_W   = ((2 * COORD_BITS + DEPTH_BITS + 3 * COLOR_W + 7) / 8) * 8;
    localparam int LATENCY     = ((COORD_BITS + FRAC_SHIFT > CFG_W) ? COORD_BITS + FRAC_SHIFT
                                                                   : CFG_W) + DEPTH_BITS + 3;
    localparam int N_CAM       = 8;
    localparam int RAND_ITEMS  = 105;
    localparam int HOLD_CYCLES = 150;
    localparam int LIMIT_CYC   = 200000;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int   fail_count;
    int   pending;
    int   points_checked;
    int   src_idle    = 15;
    int   snk_idle    = 87;
    int   stall_reqs  = 0;
    int   stalls_done = 0;
    int   pixels_sent;
    int   pixels_empty;
    cfg_t cam_tab[N_CAM];

    always #10 aclk = ~aclk;

    depth_pixel_backprojection #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    point_checker #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS),
        .S_TDATA_W (S_TDATA_W)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .points_checked(points_checked)
    );

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_camera(input cfg_t cam);
        apb_access(1'b1, REG_FOCAL_X, cam.focal_x);
        apb_access(1'b1, REG_FOCAL_Y, cam.focal_y);
        apb_access(1'b1, REG_CENTRE_X, cam.centre_x);
        apb_access(1'b1, REG_CENTRE_Y, cam.centre_y);
        apb_access(1'b0, REG_FOCAL_X, '0);
        apb_access(1'b0, REG_FOCAL_Y, '0);
        apb_access(1'b0, REG_CENTRE_X, '0);
        apb_access(1'b0, REG_CENTRE_Y, '0);
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row,
                              input logic [DEPTH_BITS-1:0] depth, input logic invalid,
                              input logic [7:0] blu, input logic [7:0] grn,
                              input logic [7:0] red);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({red, grn, blu, depth, row, col});
        s_tuser  <= invalid;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (depth == 0 || invalid)
            pixels_empty++;
    endtask

    task automatic drain_points();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // receiver: random backpressure, or one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_reqs != stalls_done) begin
                stalls_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    initial begin
        #(LIMIT_CYC * 20);
        $display("timeout with %0d points outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int                    ph;
        int                    n;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] dep;
        logic                  inv;
        pixels_sent  = 0;
        pixels_empty = 0;
        cam_tab[0] = '{FOCAL_X_RST, FOCAL_Y_RST, CENTRE_X_RST, CENTRE_Y_RST};
        cam_tab[1] = '{16'd16, 16'd16, 16'd0, 16'd0};
        cam_tab[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        cam_tab[3] = '{16'd1, 16'd1, 16'd0, 16'hFFFF};
        cam_tab[4] = '{16'd0, 16'd0, 16'd2048, 16'hFFFF};
        cam_tab[5] = '{16'd8400, 16'd8400, 16'd5120, 16'd3840};
        cam_tab[6] = '{16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                       16'($urandom), 16'($urandom)};
        cam_tab[7] = '{16'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 4095))};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < N_CAM; ph++) begin
            if (ph < 3) begin
                src_idle = 15;
                snk_idle = 87;
            end else if (ph < 6) begin
                src_idle = 87;
                snk_idle = 15;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (ph != 0)
                set_camera(cam_tab[ph]);

            case (ph)
                0: begin
                    send_pixel(12'd320, 12'd240, 16'd256, 1'b0, 8'h11, 8'h22, 8'h33);
                    send_pixel(12'd0, 12'd0, 16'hFFFF, 1'b0, 8'h00, 8'h00, 8'h00);
                    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 1'b0, 8'hFF, 8'hFF, 8'hFF);
                    send_pixel(12'd100, 12'd200, 16'd0, 1'b0, 8'h01, 8'h02, 8'h03);
                    send_pixel(12'd100, 12'd200, 16'd500, 1'b1, 8'h04, 8'h05, 8'h06);
                    send_pixel(12'd0, 12'hFFF, 16'd0, 1'b1, 8'h07, 8'h08, 8'h09);
                    send_pixel(12'hFFF, 12'd0, 16'd1, 1'b0, 8'hA5, 8'h5A, 8'h3C);
                    send_pixel(12'd2730, 12'd1365, 16'h8000, 1'b0, 8'h55, 8'hAA, 8'h0F);
                end
                3: begin
                    send_pixel(12'hFFF, 12'd0, 16'hFFFF, 1'b0, 8'h12, 8'h34, 8'h56);
                    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 1'b0, 8'h78, 8'h9A, 8'hBC);
                    send_pixel(12'd0, 12'hFFF, 16'd1, 1'b0, 8'hDE, 8'hF0, 8'h13);
                    send_pixel(12'd1000, 12'd2000, 16'h4000, 1'b0, 8'h24, 8'h35, 8'h46);
                end
                4: begin
                    send_pixel(12'hFFF, 12'd0, 16'd100, 1'b0, 8'h57, 8'h68, 8'h79);
                    send_pixel(12'd128, 12'hFFF, 16'hFFFF, 1'b0, 8'h8A, 8'h9B, 8'hAC);
                    send_pixel(12'd0, 12'd100, 16'd1, 1'b0, 8'hBD, 8'hCE, 8'hDF);
                end
                default: ;
            endcase

            for (n = 0; n < RAND_ITEMS; n++) begin
                if (ph == 6 && n == 20)
                    stall_reqs++;
                col = ($urandom_range(9) == 0) ? {COORD_BITS{1'($urandom)}}
                                               : COORD_BITS'($urandom);
                row = ($urandom_range(9) == 0) ? {COORD_BITS{1'($urandom)}}
                                               : COORD_BITS'($urandom);
                dep = ($urandom_range(3) == 0) ? DEPTH_BITS'($urandom_range(1, 255))
                                               : DEPTH_BITS'($urandom_range(1, 65535));
                inv = 1'b0;
                if ($urandom_range(99) < 15) begin
                    if ($urandom_range(1))
                        inv = 1'b1;
                    else
                        dep = '0;
                end
                send_pixel(col, row, dep, inv, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain_points();
        end

        $display("%0d pixels sent (%0d without depth), %0d points checked", pixels_sent,
                 pixels_empty, points_checked);
        $display("%0d camera settings incl. zero, minimum and full-scale focal and centre",
                 N_CAM);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: depth_pixel_backprojection.f
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_apb.sv
hw/rtl/dpb_front.sv
hw/rtl/dpb_div.sv
hw/rtl/depth_pixel_backprojection.sv
verif/point_checker.sv
verif/tb.sv
